// ----- rtl/core/plmrx_pkg.sv -----
// ----------------------------------------------------------------------------
// plmrx_pkg
// Types, codes and constants shared by the response frame receiver.
// ----------------------------------------------------------------------------
`default_nettype none

package plmrx_pkg;

  localparam logic [7:0] BYTE_STX    = 8'h02;
  localparam logic [7:0] BYTE_NAK    = 8'h15;
  localparam logic [7:0] UNSOL_FIRST = 8'h50;
  localparam logic [7:0] UNSOL_LAST  = 8'h58;

  localparam logic [4:0] MIN_FRAME = 5'd3;
  localparam logic [4:0] MAX_FRAME = 5'd28;
  localparam logic [4:0] HDR_LEN   = 5'd2;

  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_EXPECT_CMD = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_EXPECT_LEN = 1'b1;

  typedef enum logic [1:0] {
    KIND_DATA     = 2'd0,
    KIND_NAK      = 2'd1,
    KIND_BADSTART = 2'd2,
    KIND_BADCMD   = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    PH_HUNT = 2'd0,
    PH_CMD  = 2'd1,
    PH_DATA = 2'd2,
    PH_SKIP = 2'd3
  } phase_t;

  typedef struct packed {
    logic [7:0] expect_cmd;
    logic [4:0] expect_len;
  } cfg_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] data_byte;
    logic       last;
    logic       end_nak;
  } res_t;

  // body length of unsolicited messages 0x50..0x58
  function automatic logic [4:0] unsol_body(input logic [3:0] idx);
    logic [4:0] len;
    unique case (idx)
      4'd0:    len = 5'd9;
      4'd1:    len = 5'd23;
      4'd2:    len = 5'd2;
      4'd3:    len = 5'd8;
      4'd4:    len = 5'd1;
      4'd5:    len = 5'd0;
      4'd6:    len = 5'd5;
      4'd7:    len = 5'd8;
      4'd8:    len = 5'd1;
      default: len = 5'd0;
    endcase
    return len;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/plmrx_ifs.sv -----
// ----------------------------------------------------------------------------
// plmrx_ifs
// Valid/ready channels of the response frame receiver.
// ----------------------------------------------------------------------------
`default_nettype none

interface plmrx_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface plmrx_res_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] data_byte;
  logic       last;
  logic       end_nak;

  modport source (output valid, output kind, output data_byte, output last,
                  output end_nak, input ready);
  modport sink   (input valid, input kind, input data_byte, input last,
                  input end_nak, output ready);
endinterface

interface plmrx_cfg_if import plmrx_pkg::*;;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [7:0]           wdata;

  modport source (output valid, output index, output wdata, input ready);
  modport sink   (input valid, input index, input wdata, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/plm_response_frame_receiver.sv -----
// ----------------------------------------------------------------------------
// plm_response_frame_receiver
// Finds the awaited response frame in the modem's received byte stream.
// ----------------------------------------------------------------------------
//  channel  modport  payload                              use
//  rx       sink     rx_byte[7:0]                         received bytes
//  rsp      source   kind[1:0] data_byte[7:0] last end_nak  payload and errors
//  cfg      sink     index[0] wdata[7:0]                  0 expect_cmd, 1 expect_len
//
//  One byte per cycle while rsp accepts results; a result reaches rsp from its
//  transferred byte through the input register, then the result register.
//  rst (synchronous) returns the parser to hunting, expect_cmd 0, expect_len 3.
//  A stalled rsp holds the input register only when its byte gives a result.
//  cfg is always ready.
// ----------------------------------------------------------------------------
`default_nettype none

module plm_response_frame_receiver import plmrx_pkg::*; (
  input  wire clk,
  input  wire rst,
  plmrx_byte_if.sink  rx,
  plmrx_res_if.source rsp,
  plmrx_cfg_if.sink   cfg
);

  logic       s1_valid;
  logic [7:0] s1_byte;
  logic       advance;
  logic       out_free;
  logic       has_res;
  res_t       res;
  cfg_t       regs;

  plmrx_cfg u_cfg (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  assign advance  = s1_valid && (out_free || !has_res);
  assign rx.ready = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (rx.ready) begin
      s1_valid <= rx.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rx.valid && rx.ready) begin
      s1_byte <= rx.rx_byte;
    end
  end

  plmrx_parser u_parser (
    .clk     (clk),
    .rst     (rst),
    .step    (advance),
    .rx_byte (s1_byte),
    .regs    (regs),
    .has_res (has_res),
    .res     (res)
  );

  plmrx_out_stage u_out (
    .clk    (clk),
    .rst    (rst),
    .load   (advance && has_res),
    .res_in (res),
    .free   (out_free),
    .rsp    (rsp)
  );

endmodule

`default_nettype wire

// ----- rtl/core/plmrx_cfg.sv -----
// ----------------------------------------------------------------------------
// plmrx_cfg
// Configuration registers: expected command and frame length.
// ----------------------------------------------------------------------------
`default_nettype none

module plmrx_cfg import plmrx_pkg::*; (
  input  wire  clk,
  input  wire  rst,
  plmrx_cfg_if.sink cfg,
  output cfg_t regs
);

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.expect_cmd <= 8'h00;
      regs.expect_len <= MIN_FRAME;
    end else if (cfg.valid && cfg.ready) begin
      unique case (cfg.index)
        CFG_EXPECT_CMD: regs.expect_cmd <= cfg.wdata;
        CFG_EXPECT_LEN: regs.expect_len <= cfg.wdata[4:0];
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/plmrx_parser.sv -----
// ----------------------------------------------------------------------------
// plmrx_parser
// Frame state machine: decodes one registered byte per step.
// ----------------------------------------------------------------------------
`default_nettype none

module plmrx_parser import plmrx_pkg::*; (
  input  wire        clk,
  input  wire        rst,
  input  wire        step,
  input  wire  [7:0] rx_byte,
  input  wire  cfg_t regs,
  output logic       has_res,
  output res_t       res
);

  phase_t     phase, phase_next;
  logic [4:0] remaining, remaining_next;
  logic [4:0] rem_dec;
  logic [4:0] frame_len;
  logic       is_unsol;
  logic [4:0] body_len;

  always_comb begin
    if (regs.expect_len < MIN_FRAME) begin
      frame_len = MIN_FRAME;
    end else if (regs.expect_len > MAX_FRAME) begin
      frame_len = MAX_FRAME;
    end else begin
      frame_len = regs.expect_len;
    end
  end

  assign is_unsol = (rx_byte >= UNSOL_FIRST) && (rx_byte <= UNSOL_LAST);
  assign body_len = unsol_body(4'(rx_byte - UNSOL_FIRST));
  assign rem_dec  = (remaining == 5'd0) ? 5'd0 : remaining - 5'd1;

  always_comb begin
    phase_next     = phase;
    remaining_next = remaining;
    has_res        = 1'b0;
    res            = '{kind: KIND_DATA, data_byte: 8'h00, last: 1'b0, end_nak: 1'b0};
    unique case (phase)
      PH_HUNT: begin
        if (rx_byte == BYTE_NAK) begin
          has_res  = 1'b1;
          res.kind = KIND_NAK;
        end else if (rx_byte == BYTE_STX) begin
          phase_next = PH_CMD;
        end else begin
          has_res  = 1'b1;
          res.kind = KIND_BADSTART;
        end
      end
      PH_CMD: begin
        if (rx_byte == regs.expect_cmd) begin
          remaining_next = frame_len - HDR_LEN;
          phase_next     = PH_DATA;
        end else if (is_unsol) begin
          remaining_next = body_len;
          phase_next     = (body_len == 5'd0) ? PH_HUNT : PH_SKIP;
        end else begin
          remaining_next = 5'd0;
          phase_next     = PH_HUNT;
          has_res        = 1'b1;
          res.kind       = KIND_BADCMD;
        end
      end
      PH_DATA: begin
        remaining_next = rem_dec;
        has_res        = 1'b1;
        res.data_byte  = rx_byte;
        if (rem_dec == 5'd0) begin
          phase_next  = PH_HUNT;
          res.last    = 1'b1;
          res.end_nak = (rx_byte == BYTE_NAK);
        end
      end
      PH_SKIP: begin
        remaining_next = rem_dec;
        if (rem_dec == 5'd0) begin
          phase_next = PH_HUNT;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_HUNT;
      remaining <= 5'd0;
    end else if (step) begin
      phase     <= phase_next;
      remaining <= remaining_next;
    end
  end

`ifndef ASSERT_OFF
  a_data_count: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_DATA) |-> (remaining != 5'd0) && (remaining <= MAX_FRAME - HDR_LEN))
    else $error("payload count out of range");

  a_skip_count: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_SKIP) |-> (remaining != 5'd0))
    else $error("skip phase with empty body");

  a_arm: assert property (@(posedge clk) disable iff (rst)
    (step && phase == PH_HUNT && rx_byte == BYTE_STX) |=> (phase == PH_CMD))
    else $error("start byte did not arm parser");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    !step |=> $stable(phase) && $stable(remaining))
    else $error("state moved without a step");
`endif

endmodule

`default_nettype wire

// ----- rtl/core/plmrx_out_stage.sv -----
// ----------------------------------------------------------------------------
// plmrx_out_stage
// Result register driving the result channel.
// ----------------------------------------------------------------------------
`default_nettype none

module plmrx_out_stage import plmrx_pkg::*; (
  input  wire  clk,
  input  wire  rst,
  input  wire  load,
  input  wire  res_t res_in,
  output logic free,
  plmrx_res_if.source rsp
);

  logic valid;
  res_t res_q;

  assign free = !valid || rsp.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= 1'b1;
    end else if (rsp.ready) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_q <= res_in;
    end
  end

  assign rsp.valid     = valid;
  assign rsp.kind      = 2'(res_q.kind);
  assign rsp.data_byte = res_q.data_byte;
  assign rsp.last      = res_q.last;
  assign rsp.end_nak   = res_q.end_nak;

endmodule

`default_nettype wire
